### design/window_level_to_bgra_core_assert.svh
// Assertion macros for the window/level to BGRA core.
// Included by the modules that assert; expects i_clk and i_rst_n in scope.
`ifndef WINDOW_LEVEL_TO_BGRA_CORE_ASSERT_SVH
`define WINDOW_LEVEL_TO_BGRA_CORE_ASSERT_SVH
`ifndef SYNTH
`define WL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("window_level_to_bgra_core: assertion failed");
`define WL_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("window_level_to_bgra_core: reset assertion failed");
`else
`define WL_ASSERT(lbl, prop)
`define WL_ASSERT_RST(lbl, prop)
`endif
`endif

### design/wl2bgra_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and helpers of the window/level to BGRA core.
// No dependencies.
package wl2bgra_pkg;

    localparam int SampleBits = 8;
    localparam int GainBits   = 9;
    localparam int QuoBits    = 9;
    localparam int NumW       = SampleBits + GainBits;
    localparam int DivW       = SampleBits + QuoBits - 1;
    localparam int ProdW      = SampleBits + GainBits;
    localparam int NumLanes   = 4;
    localparam int InTdataW   = ((SampleBits + 7) / 8) * 8;
    localparam int OutTdataW  = 32;
    localparam int CfgDataW   = (SampleBits > GainBits) ? SampleBits : GainBits;
    localparam int CfgIdxW    = 3;

    localparam int LaneV = 0;
    localparam int LaneB = 1;
    localparam int LaneG = 2;
    localparam int LaneR = 3;

    localparam logic [CfgIdxW-1:0] RegMode      = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] RegWinLow    = CfgIdxW'(1);
    localparam logic [CfgIdxW-1:0] RegWinHigh   = CfgIdxW'(2);
    localparam logic [CfgIdxW-1:0] RegGainRed   = CfgIdxW'(3);
    localparam logic [CfgIdxW-1:0] RegGainGreen = CfgIdxW'(4);
    localparam logic [CfgIdxW-1:0] RegGainBlue  = CfgIdxW'(5);

    localparam logic [7:0] FullScale = 8'hFF;

    typedef struct packed {
        logic [SampleBits-1:0] win_low;
        logic [SampleBits-1:0] win_high;
        logic [GainBits-1:0]   gain_blue;
        logic [GainBits-1:0]   gain_green;
        logic [GainBits-1:0]   gain_red;
    } t_cfg;

    typedef struct packed {
        logic [DivW-1:0]                     div;
        logic [NumLanes-1:0][NumW-1:0]       rem;
        logic [NumLanes-1:0][QuoBits-1:0]    quo;
    } t_div_item;

    function automatic logic [7:0] sat8(input logic [QuoBits-1:0] q);
        logic [7:0] res;
        if (q > QuoBits'(FullScale)) begin
            res = FullScale;
        end else begin
            res = q[7:0];
        end
        return res;
    endfunction

endpackage

### design/wl2bgra_front.sv
`timescale 1ns / 1ps
// Front stages: window clamp, gain products and dividend forming.
// Depends on wl2bgra_pkg.
module wl2bgra_front
    import wl2bgra_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    input  logic [SampleBits-1:0] i_sample,
    output logic                  o_ready,
    output logic                  o_valid,
    output t_div_item             o_item,
    input  logic                  i_ready
);

    logic                  r_s1_valid;
    logic [SampleBits-1:0] r_s1_d;
    logic [SampleBits-1:0] r_s1_span;
    logic                  r_s2_valid;
    logic [SampleBits-1:0] r_s2_d;
    logic [SampleBits-1:0] r_s2_span;
    logic [2:0][ProdW-1:0] r_s2_prod;
    logic                  r_s3_valid;
    t_div_item             r_s3_item;

    logic                  w_rdy1, w_rdy2, w_rdy3;
    logic                  w_en;
    logic [SampleBits-1:0] w_clamped;
    logic [SampleBits-1:0] n_s1_d;
    logic [SampleBits-1:0] n_s1_span;
    logic [2:0][ProdW-1:0] n_s2_prod;
    t_div_item             n_s3_item;

    assign w_rdy3  = !r_s3_valid || i_ready;
    assign w_rdy2  = !r_s2_valid || w_rdy3;
    assign w_rdy1  = !r_s1_valid || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_s3_valid;
    assign o_item  = r_s3_item;

    // An empty or inverted window divides zero by one.
    always_comb begin
        w_en = i_cfg.win_high > i_cfg.win_low;
        if (i_sample < i_cfg.win_low) begin
            w_clamped = i_cfg.win_low;
        end else if (i_sample > i_cfg.win_high) begin
            w_clamped = i_cfg.win_high;
        end else begin
            w_clamped = i_sample;
        end
        n_s1_d    = w_en ? (w_clamped - i_cfg.win_low) : '0;
        n_s1_span = w_en ? (i_cfg.win_high - i_cfg.win_low) : SampleBits'(1);
    end

    always_comb begin
        n_s2_prod[0] = ProdW'(r_s1_d) * ProdW'(i_cfg.gain_blue);
        n_s2_prod[1] = ProdW'(r_s1_d) * ProdW'(i_cfg.gain_green);
        n_s2_prod[2] = ProdW'(r_s1_d) * ProdW'(i_cfg.gain_red);
    end

    always_comb begin
        logic [SampleBits+7:0]  v_num;
        logic [ProdW+7:0]       c_num;
        n_s3_item     = '0;
        n_s3_item.div = {r_s2_span, {(QuoBits-1){1'b0}}};
        v_num = {r_s2_d, 8'h00} - (SampleBits+8)'(r_s2_d);
        n_s3_item.rem[LaneV] = NumW'(v_num);
        for (int l = 0; l < 3; l++) begin
            c_num = {r_s2_prod[l], 8'h00} - (ProdW+8)'(r_s2_prod[l]);
            n_s3_item.rem[l+1] = c_num[ProdW+7:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (w_rdy1) r_s1_valid <= i_valid;
            if (w_rdy2) r_s2_valid <= r_s1_valid;
            if (w_rdy3) r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_s1_d    <= n_s1_d;
            r_s1_span <= n_s1_span;
        end
        if (w_rdy2 && r_s1_valid) begin
            r_s2_d    <= r_s1_d;
            r_s2_span <= r_s1_span;
            r_s2_prod <= n_s2_prod;
        end
        if (w_rdy3 && r_s2_valid) begin
            r_s3_item <= n_s3_item;
        end
    end

endmodule

### design/wl2bgra_div_cell.sv
`timescale 1ns / 1ps
// One restoring-division cell: settles one quotient bit on all four lanes.
// Depends on wl2bgra_pkg.
module wl2bgra_div_cell
    import wl2bgra_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_div_item i_item,
    output logic      o_ready,
    output logic      o_valid,
    output t_div_item o_item,
    input  logic      i_ready
);

    logic                r_valid;
    t_div_item           r_item;
    logic [NumLanes-1:0] w_take;
    t_div_item           n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        for (int l = 0; l < NumLanes; l++) begin
            w_take[l] = i_item.rem[l] >= NumW'(i_item.div);
        end
    end

    // The divisor moves down one bit per cell, so every cell is the same.
    always_comb begin
        n_item     = i_item;
        n_item.div = i_item.div >> 1;
        for (int l = 0; l < NumLanes; l++) begin
            if (w_take[l]) begin
                n_item.rem[l] = i_item.rem[l] - NumW'(i_item.div);
            end
            n_item.quo[l] = {i_item.quo[l][QuoBits-2:0], w_take[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

### design/window_level_to_bgra_core.sv
`timescale 1ns / 1ps
// Window/level intensity mapping of one sample per item to a BGRA pixel.
// Depends on wl2bgra_pkg, wl2bgra_front and wl2bgra_div_cell.
//
// The core takes one sample per clock unless the output stalls and returns
// one BGRA pixel per sample, in order: three front stages clamp the sample and
// form the products, a chain of nine division cells settles one quotient bit
// each for the intensity and the three color channels, and an output register
// saturates and packs the pixel. Every stage holds its item only while the
// next one is full, so bubbles are squeezed out when the output stalls. The
// user must write configuration only while no item is in flight; the core does not enforce this.
`include "window_level_to_bgra_core_assert.svh"
module window_level_to_bgra_core
    import wl2bgra_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CfgIdxW-1:0]    i_cfg_index,
    input  logic [CfgDataW-1:0]   i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [InTdataW-1:0]   s_axis_tdata,   // sample
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OutTdataW-1:0]  m_axis_tdata    // blue_out, green_out, red_out, alpha_out
);

    logic                  r_mode;
    t_cfg                  r_cfg;
    logic                  r_out_valid;
    logic [OutTdataW-1:0]  r_out_data;
    logic [OutTdataW-1:0]  n_out_data;

    logic                  w_valid [0:QuoBits];
    logic                  w_ready [0:QuoBits];
    t_div_item             w_item  [0:QuoBits];
    logic                  w_out_ready;
    logic [7:0]            w_v, w_b, w_g, w_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= 1'b0;
            r_cfg.win_low    <= '0;
            r_cfg.win_high   <= SampleBits'(255);
            r_cfg.gain_red   <= GainBits'(256);
            r_cfg.gain_green <= GainBits'(256);
            r_cfg.gain_blue  <= GainBits'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegMode:      r_mode           <= i_cfg_data[0];
                RegWinLow:    r_cfg.win_low    <= i_cfg_data[SampleBits-1:0];
                RegWinHigh:   r_cfg.win_high   <= i_cfg_data[SampleBits-1:0];
                RegGainRed:   r_cfg.gain_red   <= i_cfg_data[GainBits-1:0];
                RegGainGreen: r_cfg.gain_green <= i_cfg_data[GainBits-1:0];
                RegGainBlue:  r_cfg.gain_blue  <= i_cfg_data[GainBits-1:0];
                default: begin
                end
            endcase
        end
    end

    wl2bgra_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (s_axis_tvalid),
        .i_sample (s_axis_tdata[SampleBits-1:0]),
        .o_ready  (s_axis_tready),
        .o_valid  (w_valid[0]),
        .o_item   (w_item[0]),
        .i_ready  (w_ready[0])
    );

    for (genvar k = 0; k < QuoBits; k++) begin : g_cell
        wl2bgra_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .i_item  (w_item[k]),
            .o_ready (w_ready[k]),
            .o_valid (w_valid[k+1]),
            .o_item  (w_item[k+1]),
            .i_ready (w_ready[k+1])
        );
    end

    assign w_out_ready      = !r_out_valid || m_axis_tready;
    assign w_ready[QuoBits] = w_out_ready;

    always_comb begin
        w_v = sat8(w_item[QuoBits].quo[LaneV]);
        w_b = sat8(w_item[QuoBits].quo[LaneB]);
        w_g = sat8(w_item[QuoBits].quo[LaneG]);
        w_r = sat8(w_item[QuoBits].quo[LaneR]);
        if (r_mode) begin
            n_out_data = {w_v, w_r, w_g, w_b};
        end else begin
            n_out_data = {FullScale, w_v, w_v, w_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_valid[QuoBits];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && w_valid[QuoBits]) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `WL_ASSERT_RST(a_rst_empty, !i_rst_n |=> !m_axis_tvalid)
    `WL_ASSERT(a_free_out_accepts, w_out_ready |-> s_axis_tready)
    `WL_ASSERT(a_last_cell_moves, w_valid[QuoBits] && w_out_ready |=> m_axis_tvalid)
    `WL_ASSERT(a_intensity_range, w_valid[QuoBits] |-> !w_item[QuoBits].quo[LaneV][QuoBits-1])

endmodule
